// ----- src/thread_slot_round_robin_scheduler_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Thread slot scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tsrr_pkg.sv -----
// ----------------------------------------------------------------------------
// Thread slot scheduler package
// Field widths, request codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package tsrr_pkg;

  // field widths of the transaction ports
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = 4;
  localparam int CFG_W   = 5;
  localparam int RUN_W   = 5;

  // active slot register value after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_KILL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_READ,
    ST_OUT
  } tsrr_state_t;

endpackage

// ----- src/tsrr_entry_mem.sv -----
// ----------------------------------------------------------------------------
// Thread slot entry memory
// One write port, one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tsrr_entry_mem
  import tsrr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   written;

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

endmodule

// ----- src/thread_slot_round_robin_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Thread slot round-robin scheduler
// Slot allocation, kill and round-robin switch over a small thread slot pool.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_stall stays high from acceptance until
// the result transaction has been taken. All searches run through a single
// step adder under the sequencer, one slot per cycle. A start scans the slots
// in ST_SCAN and then offers its result in ST_OUT (rejections on a full pool
// go straight to ST_OUT); an accepted kill passes through ST_READ to ST_OUT;
// a switch subtracts lim in ST_MOD while folding current+1 into range, visits
// slots in the wrap-around search in ST_SCAN, then reads the entry in ST_READ
// and offers the result in ST_OUT. lim is active_slots clamped to
// 1..MAX_SLOTS; slot 0 is always occupied, so every search ends.
// ----------------------------------------------------------------------------
`include "thread_slot_round_robin_scheduler_unit_defines.svh"

module thread_slot_round_robin_scheduler_unit
  import tsrr_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   active_slots,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [IDX_W-1:0]   target_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic [IDX_W-1:0]   slot,
  output logic               switched,
  output logic [ENTRY_W-1:0] entry,
  output logic [RUN_W-1:0]   running
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  // control state
  tsrr_state_t          state;
  tsrr_state_t          state_next;
  logic [CFG_W-1:0]     cfg_slots;
  logic [MAX_SLOTS-1:0] slot_free;
  logic [SW-1:0]        current_slot;
  logic [CW-1:0]        running_count;

  // transaction payload and search pointer
  logic [REQ_W-1:0]     req_reg;
  logic [IDX_W-1:0]     tgt_reg;
  logic [CW-1:0]        ptr;
  logic                 res_accepted;
  logic [IDX_W-1:0]     res_slot;
  logic                 res_switched;
  logic [ENTRY_W-1:0]   res_entry;

  // derived values
  logic [CW-1:0]        lim;
  logic [SW-1:0]        ptr_idx;
  logic [SW-1:0]        tgt_slot;
  logic                 ptr_free;
  logic                 ptr_over;
  logic                 kill_ok;
  logic                 start_full;
  logic                 start_alloc;
  logic                 switch_hit;
  logic                 take_in;

  // shared step adder
  logic [CW-1:0]        add_b;
  logic                 add_cin;
  logic [CW-1:0]        add_sum;

  // entry memory port
  logic                 mem_wr_en;
  logic                 mem_rd_en;
  logic [SW-1:0]        mem_rd_addr;
  logic [ENTRY_W-1:0]   mem_rd_data;

  // effective slot limit
  always_comb begin
    if (cfg_slots == '0) begin
      lim = CW'(1);
    end else if (int'(cfg_slots) > MAX_SLOTS) begin
      lim = CW'(MAX_SLOTS);
    end else begin
      lim = CW'(cfg_slots);
    end
  end

  // request checks
  always_comb begin
    ptr_idx     = ptr[SW-1:0];
    tgt_slot    = SW'(target_index);
    ptr_over    = (ptr >= lim);
    ptr_free    = slot_free[ptr_idx];
    take_in     = in_valid && (state == ST_IDLE);
    start_full  = (running_count >= lim);
    kill_ok     = (target_index != '0) && (int'(target_index) < MAX_SLOTS) &&
                  (running_count > CW'(1)) && !slot_free[tgt_slot];
    start_alloc = (state == ST_SCAN) && (req_reg == REQ_START) && !ptr_over && ptr_free;
    switch_hit  = (state == ST_SCAN) && (req_reg == REQ_SWITCH) && !ptr_free;
  end

  // step adder: subtract lim while folding, add one while scanning
  always_comb begin
    add_cin = (state == ST_MOD);
    add_b   = (state == ST_MOD) ? ~lim : CW'(1);
    add_sum = ptr + add_b + CW'(add_cin);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_START:  state_next = start_full ? ST_OUT : ST_SCAN;
            REQ_KILL:   state_next = kill_ok ? ST_READ : ST_OUT;
            REQ_SWITCH: state_next = ST_MOD;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_MOD: begin
        if (!ptr_over) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (req_reg == REQ_START) begin
          if (ptr_over || ptr_free) begin
            state_next = ST_OUT;
          end
        end else if (!ptr_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and memory control
  always_comb begin
    cfg_ready   = 1'b1;
    in_stall    = (state != ST_IDLE);
    out_valid   = (state == ST_OUT);
    mem_wr_en   = start_alloc;
    mem_rd_en   = (take_in && (req_type == REQ_KILL) && kill_ok) || switch_hit;
    mem_rd_addr = (state == ST_IDLE) ? tgt_slot : ptr_idx;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cfg_slots     <= CFG_RESET;
      slot_free     <= {MAX_SLOTS{1'b1}} ^ MAX_SLOTS'(1);
      current_slot  <= '0;
      running_count <= CW'(1);
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        cfg_slots <= active_slots;
      end
      if (take_in && (req_type == REQ_KILL) && kill_ok) begin
        slot_free[tgt_slot] <= 1'b1;
        running_count       <= running_count - CW'(1);
      end
      if (start_alloc) begin
        slot_free[ptr_idx] <= 1'b0;
        running_count      <= running_count + CW'(1);
      end
      if (switch_hit) begin
        current_slot <= ptr_idx;
      end
    end
  end

  // payload registers and search pointer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_reg      <= req_type;
          tgt_reg      <= target_index;
          res_accepted <= (req_type == REQ_KILL) && kill_ok;
          res_slot     <= ((req_type == REQ_KILL) && kill_ok) ? target_index : '0;
          res_switched <= 1'b0;
          res_entry    <= '0;
          ptr          <= (req_type == REQ_SWITCH) ? CW'(current_slot) + CW'(1) : '0;
        end
      end
      ST_MOD: begin
        if (ptr_over) begin
          ptr <= add_sum;
        end
      end
      ST_SCAN: begin
        if (req_reg == REQ_START) begin
          if (start_alloc) begin
            res_accepted <= 1'b1;
            res_slot     <= IDX_W'(ptr_idx);
            res_entry    <= tgt_reg;
          end else if (!ptr_over) begin
            ptr <= add_sum;
          end
        end else if (switch_hit) begin
          res_slot     <= IDX_W'(ptr_idx);
          res_accepted <= (ptr_idx != current_slot);
          res_switched <= (ptr_idx != current_slot);
        end else begin
          ptr <= (add_sum == lim) ? '0 : add_sum;
        end
      end
      ST_READ: begin
        res_entry <= mem_rd_data;
      end
      default: begin
      end
    endcase
  end

  // program entry store
  tsrr_entry_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (SW)
  ) u_entry_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_addr (ptr_idx),
    .wr_data (tgt_reg),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // result transaction
  assign accepted = res_accepted;
  assign slot     = res_slot;
  assign switched = res_switched;
  assign entry    = res_entry;
  assign running  = RUN_W'(running_count);

  // checks
  `TSRR_ASSERT_NOW(a_slot0_held, 1'b1, !slot_free[0], "slot 0 was freed")
  `TSRR_ASSERT_NOW(a_count_match, 1'b1, running_count == CW'($countones(~slot_free)), "running count mismatch")
  `TSRR_ASSERT_NOW(a_busy_while_result, out_valid, in_stall, "request taken while result pending")
  `TSRR_ASSERT_NEXT(a_result_once, out_valid && !out_stall, !out_valid, "result repeated")

endmodule
